// ===== hw/rtl/b64e_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64e_pkg: shared types and constants for the Base64 stream encoder
// Beat payloads, the group record passed from front to back, and the
// symbol-to-ASCII mapping.
// ============================================================================
package b64e_pkg;

    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned Q_DEPTH  = 2;

    // register word index (paddr[2])
    localparam logic REG_URL_SAFE = 1'b0;

    localparam logic [6:0] PAD_CHAR = 7'd61;  // '='

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out_item;

    // One finished group, ready to be turned into characters.
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  last_data;  // index of last data symbol (1..3)
        logic [1:0]  last_idx;   // index of last character emitted (1..3)
        logic        last;       // message ends with this group
        logic        url;        // alphabet latched at group time
    } t_grp;

    // 6-bit symbol to ASCII, standard or URL-safe alphabet
    function automatic logic [6:0] b64e_map(input logic [5:0] sym, input logic url);
        logic [6:0] v;
        logic [6:0] r;
        v = {1'b0, sym};
        if (sym < 6'd26) begin
            r = 7'd65 + v;
        end else if (sym < 6'd52) begin
            r = 7'd71 + v;            // 'a' - 26
        end else if (sym < 6'd62) begin
            r = v - 7'd4;             // '0' - 52
        end else if (sym == 6'd62) begin
            r = url ? 7'd45 : 7'd43;  // '-' or '+'
        end else begin
            r = url ? 7'd95 : 7'd47;  // '_' or '/'
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/b64e_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64e_front: byte gatherer
// Collects up to three bytes and hands a finished group record to the queue.
// ============================================================================
module b64e_front
    import b64e_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    input  wire logic     i_q_full,
    input  wire logic     i_url_safe,
    output logic          o_full,
    output logic          o_q_wr,
    output t_grp          o_q_data
);

    logic [15:0] r_held;
    logic [15:0] n_held;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        accept;
    logic        done;
    logic [1:0]  total_m1;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    // count of three cannot occur; treated as two
    assign done   = i_item.last_byte || r_cnt[1];
    assign o_q_wr = accept && done;

    always_comb begin
        n_held   = r_held;
        n_cnt    = r_cnt;
        total_m1 = r_cnt[1] ? 2'd2 : r_cnt;
        o_q_data.last_data = total_m1 + 2'd1;
        o_q_data.last_idx  = i_url_safe ? total_m1 + 2'd1 : 2'd3;
        o_q_data.last      = i_item.last_byte;
        o_q_data.url       = i_url_safe;
        case (r_cnt)
            2'd0:    o_q_data.group = {i_item.data_byte, 16'd0};
            2'd1:    o_q_data.group = {r_held[15:8], i_item.data_byte, 8'd0};
            default: o_q_data.group = {r_held, i_item.data_byte};
        endcase
        if (accept) begin
            if (done) begin
                n_held = '0;
                n_cnt  = '0;
            end else begin
                if (r_cnt == 2'd0) begin
                    n_held = {i_item.data_byte, 8'd0};
                end else begin
                    n_held = {r_held[15:8], i_item.data_byte};
                end
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= '0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/b64e_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64e_queue: two-entry group queue
// Decouples the byte gatherer from the character sequencer.
// ============================================================================
module b64e_queue
    import b64e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_grp i_wdata,
    input  wire logic i_rd,
    output logic      o_full,
    output logic      o_empty,
    output t_grp      o_rdata
);

    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);
    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_grp             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (!o_full || i_rd))
        else $error("group queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("group queue read while empty");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/b64e_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64e_back: character sequencer
// Walks the head group one symbol per cycle into the output register, while a group
// is queued and the output register is empty or being popped.
module b64e_back
    import b64e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_grp i_q_data,
    input  wire logic i_pop,
    output logic      o_q_rd,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_out;
    logic       load;
    logic [5:0] sym;
    t_out_item  nxt;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd  = load && (r_idx == i_q_data.last_idx);
    assign o_empty = !r_valid;
    assign o_item  = r_out;

    always_comb begin
        case (r_idx)
            2'd0:    sym = i_q_data.group[23:18];
            2'd1:    sym = i_q_data.group[17:12];
            2'd2:    sym = i_q_data.group[11:6];
            default: sym = i_q_data.group[5:0];
        endcase
        nxt.out_char  = (r_idx <= i_q_data.last_data) ? b64e_map(sym, i_q_data.url)
                                                      : PAD_CHAR;
        nxt.last_char = i_q_data.last && (r_idx == i_q_data.last_idx);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= o_q_rd ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_mid_group_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> !i_q_empty)
        else $error("sequencer mid-group with no group queued");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (r_idx <= i_q_data.last_idx))
        else $error("sequencer index past last character");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A group-closing byte's group is queued, then its first character is registered.
// Throughput: the character sequencer gives one character per cycle while a group
//   is queued and the output is empty or popped; three bytes make four characters.
// The byte side takes one beat per cycle while the two-entry group queue has room.
// Reset: i_rst_n synchronous, active low; clears held bytes, queue, output valid and
//   url_safe (standard padded alphabet).
// ============================================================================
// base64_stream_encoder: streaming Base64 encoder
// Front gathers bytes into 24-bit groups, a short queue holds finished groups,
// the back end emits one ASCII character per beat with '=' padding in
// standard mode. APB register 0 (byte address 0) holds url_safe.
// ============================================================================
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte side
    input  wire logic               push,
    output logic                    full,
    input  wire t_in_item           i_in_item,
    // character side
    output logic                    empty,
    input  wire logic               pop,
    output t_out_item               o_out_item,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic r_url_safe;
    logic cfg_wr;

    // group path between front and back
    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_empty;
    t_grp q_wdata;
    t_grp q_rdata;

    // ---- register port: one register, word index from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url_safe <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_URL_SAFE)) begin
            r_url_safe <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_URL_SAFE) ? {{(PDATA_W-1){1'b0}}, r_url_safe} : '0;

    // ---- front: byte gatherer; alphabet is latched with each group
    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in_item),
        .i_q_full   (q_full),
        .i_url_safe (r_url_safe),
        .o_full     (full),
        .o_q_wr     (q_wr),
        .o_q_data   (q_wdata)
    );

    // ---- queue: lets the front keep taking beats while characters drain
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    // ---- back: one character per beat into an output register
    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .i_pop     (pop),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule
`default_nettype wire
